// File: sv/gde_pkg.sv
// Shared types, constants and helpers for the 5x7 glyph dot emitter.
// Holds the font table, the queue entry and the lookup, size and saturation helpers.
// Depends on nothing else; every other design file imports it.
`default_nettype none

package gde_pkg;

  localparam int GlyphRows = 7;
  localparam int GlyphCols = 5;
  localparam int GlyphBits = GlyphRows * GlyphCols;
  localparam int NumGlyphs = 42;

  localparam logic [5:0] GlyphDigit0 = 6'd26;
  localparam logic [5:0] GlyphColon  = 6'd36;
  localparam logic [5:0] GlyphPeriod = 6'd37;
  localparam logic [5:0] GlyphMinus  = 6'd38;
  localparam logic [5:0] GlyphUnder  = 6'd39;
  localparam logic [5:0] GlyphBox    = 6'd40;
  localparam logic [5:0] GlyphBlank  = 6'd41;

  localparam logic [7:0] DotScaleNum = 8'd236;

  // Row 0 sits in the top five bits, the leftmost column of each row first.
  localparam logic [GlyphBits-1:0] FontRom [NumGlyphs] = '{
    {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11},
    {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E},
    {5'h0F, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h0F},
    {5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E},
    {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F},
    {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10},
    {5'h0F, 5'h10, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0F},
    {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11},
    {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F},
    {5'h01, 5'h01, 5'h01, 5'h01, 5'h11, 5'h11, 5'h0E},
    {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11},
    {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F},
    {5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11},
    {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11},
    {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E},
    {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10},
    {5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D},
    {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11},
    {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E},
    {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04},
    {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E},
    {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04},
    {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h1B, 5'h11},
    {5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11},
    {5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04},
    {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F},
    {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E},
    {5'h04, 5'h0C, 5'h14, 5'h04, 5'h04, 5'h04, 5'h1F},
    {5'h0E, 5'h11, 5'h01, 5'h06, 5'h08, 5'h10, 5'h1F},
    {5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E},
    {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02},
    {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E},
    {5'h07, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E},
    {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08},
    {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E},
    {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h1C},
    {5'h00, 5'h04, 5'h00, 5'h00, 5'h00, 5'h04, 5'h00},
    {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h06, 5'h06},
    {5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00},
    {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h1F},
    {5'h1F, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1F},
    {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00}
  };

  typedef struct packed {
    logic [GlyphBits-1:0] bitmap;
    logic signed [15:0]   pen_x;
    logic signed [15:0]   pen_y;
    logic [11:0]          pitch;
    logic [11:0]          side;
    logic [31:0]          color;
  } gde_job_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [11:0]        size;
    logic [31:0]        color;
    logic               last;
  } gde_dot_t;

  typedef struct packed {
    logic full;
    logic empty;
  } gde_qstat_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } gde_state_e;

  function automatic logic [5:0] glyph_index(input logic [7:0] code);
    logic [7:0] c;
    logic [5:0] idx;
    c = code;
    if (c >= 8'h61 && c <= 8'h7A) begin
      c = c - 8'h20;
    end
    if (c >= 8'h41 && c <= 8'h5A) begin
      idx = 6'(c - 8'h41);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      idx = GlyphDigit0 + 6'(c - 8'h30);
    end else begin
      case (c)
        8'h3A:   idx = GlyphColon;
        8'h2E:   idx = GlyphPeriod;
        8'h2D:   idx = GlyphMinus;
        8'h5F:   idx = GlyphUnder;
        8'h20:   idx = GlyphBlank;
        default: idx = GlyphBox;
      endcase
    end
    return idx;
  endfunction

  function automatic logic [11:0] side_of(input logic [11:0] pitch);
    logic [19:0] prod;
    prod = pitch * DotScaleNum;
    return prod[19:8];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    logic signed [15:0] r;
    if (v > 18'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -18'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: sv/gde_front.sv
// Front end of the glyph dot emitter: accepts characters, keeps the pen state.
// Looks each code up in the font table and pushes a job to the queue.
// Depends on gde_pkg.
`default_nettype none

module gde_front #(
  parameter int FRACTION_BITS = 4
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               accept_i,
  input  wire logic [7:0]         char_code_i,
  input  wire logic               first_char_i,
  input  wire logic signed [15:0] origin_x_i,
  input  wire logic signed [15:0] origin_y_i,
  input  wire logic [11:0]        cell_size_i,
  input  wire logic [31:0]        ink_color_i,
  output gde_pkg::gde_job_t       job_o
);
  import gde_pkg::*;

  localparam logic [11:0] DefPitch = 12'(2 << FRACTION_BITS);
  localparam logic [11:0] DefSide  = side_of(DefPitch);

  logic signed [15:0] pen_x_q, pen_x_d;
  logic signed [15:0] pen_y_q, pen_y_d;
  logic [11:0]        pitch_q, pitch_d;
  logic [11:0]        side_q, side_d;
  logic [31:0]        color_q, color_d;
  logic [14:0]        advance;
  logic signed [17:0] pen_sum;

  always_comb begin
    if (first_char_i) begin
      pen_x_d = origin_x_i;
      pen_y_d = origin_y_i;
      pitch_d = (cell_size_i == 12'd0) ? DefPitch : cell_size_i;
      side_d  = side_of(pitch_d);
      color_d = ink_color_i;
    end else begin
      pen_x_d = pen_x_q;
      pen_y_d = pen_y_q;
      pitch_d = pitch_q;
      side_d  = side_q;
      color_d = color_q;
    end
    advance = {1'b0, pitch_d, 2'b00} + {2'b00, pitch_d, 1'b0};
    pen_sum = 18'(pen_x_d) + $signed({3'b000, advance});
  end

  assign job_o.bitmap = FontRom[glyph_index(char_code_i)];
  assign job_o.pen_x  = pen_x_d;
  assign job_o.pen_y  = pen_y_d;
  assign job_o.pitch  = pitch_d;
  assign job_o.side   = side_d;
  assign job_o.color  = color_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_x_q <= '0;
      pen_y_q <= '0;
      pitch_q <= DefPitch;
      side_q  <= DefSide;
      color_q <= '0;
    end else if (accept_i) begin
      pen_x_q <= sat16(pen_sum);
      pen_y_q <= pen_y_d;
      pitch_q <= pitch_d;
      side_q  <= side_d;
      color_q <= color_d;
    end
  end

endmodule

`default_nettype wire

// File: sv/gde_queue.sv
// Short job queue between the front and back ends of the glyph dot emitter.
// A small register ring with a fill count; depends on gde_pkg.
`default_nettype none

module gde_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire gde_pkg::gde_job_t push_data_i,
  input  wire logic         pop_i,
  output gde_pkg::gde_job_t pop_data_o,
  output gde_pkg::gde_qstat_t stat_o
);
  import gde_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  gde_job_t        ring_q [DEPTH];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ring_q[wr_q] <= push_data_i;
    end
  end

  assign pop_data_o   = ring_q[rd_q];
  assign stat_o.full  = (cnt_q == FullCnt);
  assign stat_o.empty = (cnt_q == '0);

endmodule

`default_nettype wire

// File: sv/gde_back.sv
// Glyph dot emitter back end: walks a bitmap one cell a cycle unless stalled.
// Emits one dot per lit cell through an output register; depends on gde_pkg.
`default_nettype none

module gde_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire gde_pkg::gde_qstat_t qstat_i,
  input  wire gde_pkg::gde_job_t   job_i,
  output logic                pop_o,
  output logic                dot_valid_o,
  input  wire logic           dot_ready_i,
  output gde_pkg::gde_dot_t   dot_o
);
  import gde_pkg::*;

  localparam logic [2:0] LastCol = 3'(GlyphCols - 1);

  gde_state_e           state_q, state_d;
  logic [GlyphBits-1:0] bm_q, rest;
  logic [2:0]           col_q;
  logic signed [17:0]   x_q, y_q, base_q;
  logic [11:0]          pitch_q, side_q;
  logic [31:0]          color_q;
  logic                 ov_q;
  gde_dot_t             dot_q;
  logic                 out_free, step, emit, load;

  assign rest     = {bm_q[GlyphBits-2:0], 1'b0};
  assign out_free = !ov_q || dot_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (!qstat_i.empty && job_i.bitmap != '0) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (step && rest == '0) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    load = 1'b0;
    step = 1'b0;
    emit = 1'b0;
    case (state_q)
      ST_IDLE: begin
        load = !qstat_i.empty;
      end
      ST_RUN: begin
        step = !bm_q[GlyphBits-1] || out_free;
        emit = bm_q[GlyphBits-1] && out_free;
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  assign pop_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit) begin
        ov_q <= 1'b1;
      end else if (dot_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      bm_q    <= job_i.bitmap;
      col_q   <= '0;
      x_q     <= 18'(job_i.pen_x);
      base_q  <= 18'(job_i.pen_x);
      y_q     <= 18'(job_i.pen_y);
      pitch_q <= job_i.pitch;
      side_q  <= job_i.side;
      color_q <= job_i.color;
    end else if (step) begin
      bm_q <= rest;
      if (col_q == LastCol) begin
        col_q <= '0;
        x_q   <= base_q;
        y_q   <= y_q + $signed({6'd0, pitch_q});
      end else begin
        col_q <= col_q + 1'b1;
        x_q   <= x_q + $signed({6'd0, pitch_q});
      end
    end
    if (emit) begin
      dot_q.x     <= sat16(x_q);
      dot_q.y     <= sat16(y_q);
      dot_q.size  <= side_q;
      dot_q.color <= color_q;
      dot_q.last  <= (rest == '0);
    end
  end

  assign dot_valid_o = ov_q;
  assign dot_o       = dot_q;

endmodule

`default_nettype wire

// File: sv/glyph_dot_emitter_5x7.sv
// Top level of the 5x7 glyph dot emitter: front end, job queue, back end.
// Depends on gde_pkg, gde_front, gde_queue and gde_back.
//
// Channel  Direction  Handshake                     Moves
// s_axis   in         s_axis_tvalid/s_axis_tready   one character request
// m_axis   out        m_axis_tvalid/m_axis_tready   one dot request
//
// Each character is first loaded from the queue as a job, then the back end walks
// one font cell per cycle, unless the output stalls, up to its last lit cell,
// at most 35 cells; the cell walk of the back end bounds each character. A blank
// character is only loaded and never walked. The queue holds QUEUE_DEPTH
// characters, so the input keeps accepting while the back end draws, until full.
// Reset is asynchronous and active low and returns the pen to its defaults.
// A stall on the output holds the back end on the next lit cell only.
`default_nettype none

module glyph_dot_emitter_5x7 #(
  parameter int FRACTION_BITS = 4,
  parameter int QUEUE_DEPTH   = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // char_code[7:0], origin_x[23:8], origin_y[39:24], cell_size[51:40],
  // ink_color[83:52], zero fill[87:84]
  input  wire logic [87:0] s_axis_tdata,
  // first_char[0]
  input  wire logic        s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // dot_x[15:0], dot_y[31:16], dot_size[43:32], dot_color[75:44],
  // zero fill[79:76]
  output logic [79:0]      m_axis_tdata,
  // last_dot
  output logic             m_axis_tlast
);
  import gde_pkg::*;

  gde_job_t   push_job, pop_job;
  gde_qstat_t qstat;
  gde_dot_t   dot;
  logic       push, pop;

  assign s_axis_tready = !qstat.full;
  assign push          = s_axis_tvalid && s_axis_tready;

  gde_front #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (push),
    .char_code_i (s_axis_tdata[7:0]),
    .first_char_i(s_axis_tuser),
    .origin_x_i  ($signed(s_axis_tdata[23:8])),
    .origin_y_i  ($signed(s_axis_tdata[39:24])),
    .cell_size_i (s_axis_tdata[51:40]),
    .ink_color_i (s_axis_tdata[83:52]),
    .job_o       (push_job)
  );

  gde_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_job),
    .pop_i      (pop),
    .pop_data_o (pop_job),
    .stat_o     (qstat)
  );

  gde_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .qstat_i    (qstat),
    .job_i      (pop_job),
    .pop_o      (pop),
    .dot_valid_o(m_axis_tvalid),
    .dot_ready_i(m_axis_tready),
    .dot_o      (dot)
  );

  assign m_axis_tdata = {4'd0, dot.color, dot.size, dot.y, dot.x};
  assign m_axis_tlast = dot.last;

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !qstat.empty)
    else $error("queue popped while empty");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !qstat.full)
    else $error("queue pushed while full");

  a_stat_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(qstat.full && qstat.empty))
    else $error("queue reports full and empty together");

endmodule

`default_nettype wire

// File: test/glyph_dot_emitter_5x7_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for glyph_dot_emitter_5x7: character requests go in on s_axis,
// a local predictor builds the expected dot requests and a checker compares them on m_axis.
// Depends only on the glyph_dot_emitter_5x7 RTL and its package.

module glyph_dot_emitter_5x7_tb;

  localparam int FracBits      = 4;
  localparam logic [11:0] DefaultPitch = 12'(2 << FracBits);
  localparam int DotScale      = 236;
  localparam int AdvanceCells  = 6;
  localparam int GlyphRows     = 7;
  localparam int GlyphCols     = 5;
  localparam int IdlePercent   = 30;
  localparam int DrainCycles   = 40;
  localparam int WatchdogLimit = 2000;
  localparam int ReportLimit   = 10;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [11:0]        size;
    logic [31:0]        color;
    logic               last;
  } glyph_dot_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [79:0] m_axis_tdata;
  logic        m_axis_tlast;

  logic signed [15:0] pen_x;
  logic signed [15:0] pen_y;
  logic [11:0]        pitch;
  logic [11:0]        dot_side;
  logic [31:0]        ink;

  glyph_dot_t expected_dots[$];
  int  mismatches;
  int  items_sent;
  int  directed_items;
  int  dots_checked;
  int  quiet_cycles;
  bit  calm;

  glyph_dot_emitter_5x7 i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [34:0] glyph_map(input logic [7:0] code);
    logic [7:0]  ch;
    logic [34:0] m;
    ch = code;
    if (ch >= "a" && ch <= "z") begin
      ch = ch - 8'h20;
    end
    case (ch)
      "A": m = {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
      "B": m = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E};
      "C": m = {5'h0F, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h0F};
      "D": m = {5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E};
      "E": m = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
      "F": m = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10};
      "G": m = {5'h0F, 5'h10, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0F};
      "H": m = {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
      "I": m = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F};
      "J": m = {5'h01, 5'h01, 5'h01, 5'h01, 5'h11, 5'h11, 5'h0E};
      "K": m = {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
      "L": m = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
      "M": m = {5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
      "N": m = {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11};
      "O": m = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
      "P": m = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
      "Q": m = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D};
      "R": m = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11};
      "S": m = {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E};
      "T": m = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
      "U": m = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
      "V": m = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04};
      "W": m = {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h1B, 5'h11};
      "X": m = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11};
      "Y": m = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04};
      "Z": m = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F};
      "0": m = {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
      "1": m = {5'h04, 5'h0C, 5'h14, 5'h04, 5'h04, 5'h04, 5'h1F};
      "2": m = {5'h0E, 5'h11, 5'h01, 5'h06, 5'h08, 5'h10, 5'h1F};
      "3": m = {5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E};
      "4": m = {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
      "5": m = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E};
      "6": m = {5'h07, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
      "7": m = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
      "8": m = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
      "9": m = {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h1C};
      ":": m = {5'h00, 5'h04, 5'h00, 5'h00, 5'h00, 5'h04, 5'h00};
      ".": m = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h06, 5'h06};
      "-": m = {5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00};
      "_": m = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h1F};
      " ": m = '0;
      default: m = {5'h1F, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1F};
    endcase
    return m;
  endfunction

  function automatic logic signed [15:0] clamp16(input int v);
    logic signed [15:0] r;
    if (v > 32767) begin
      r = 16'sh7FFF;
    end else if (v < -32768) begin
      r = 16'sh8000;
    end else begin
      r = 16'(v);
    end
    return r;
  endfunction

  task automatic predict_dots(input logic [7:0] code, input logic first,
                              input logic [15:0] ox, input logic [15:0] oy,
                              input logic [11:0] cs, input logic [31:0] color);
    logic [34:0] map;
    glyph_dot_t  pending;
    bit          have_pending;
    int          prod;
    have_pending = 1'b0;
    pending = '0;
    if (first) begin
      pen_x = ox;
      pen_y = oy;
      pitch = (cs == 12'd0) ? DefaultPitch : cs;
      prod = int'(pitch) * DotScale;
      dot_side = 12'(prod >> 8);
      ink = color;
    end
    map = glyph_map(code);
    for (int r = 0; r < GlyphRows; r++) begin
      for (int c = 0; c < GlyphCols; c++) begin
        if (map[34 - (r * GlyphCols + c)]) begin
          if (have_pending) begin
            expected_dots.push_back(pending);
          end
          pending.x = clamp16(int'(pen_x) + c * int'(pitch));
          pending.y = clamp16(int'(pen_y) + r * int'(pitch));
          pending.size = dot_side;
          pending.color = ink;
          pending.last = 1'b0;
          have_pending = 1'b1;
        end
      end
    end
    if (have_pending) begin
      pending.last = 1'b1;
      expected_dots.push_back(pending);
    end
    pen_x = clamp16(int'(pen_x) + AdvanceCells * int'(pitch));
  endtask

  task automatic send_char(input logic [7:0] code, input logic first,
                           input logic [15:0] ox, input logic [15:0] oy,
                           input logic [11:0] cs, input logic [31:0] color);
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < IdlePercent) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tdata  <= {4'b0, color, cs, oy, ox, code};
    s_axis_tuser  <= first;
    s_axis_tvalid <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic drain_dots();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_dots.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  function automatic logic [7:0] random_code();
    int r;
    logic [7:0] punct [5];
    punct = '{":", ".", "-", "_", " "};
    r = $urandom_range(99);
    if (r < 35) begin
      return 8'("A" + $urandom_range(25));
    end else if (r < 60) begin
      return 8'("a" + $urandom_range(25));
    end else if (r < 75) begin
      return 8'("0" + $urandom_range(9));
    end else if (r < 85) begin
      return punct[$urandom_range(4)];
    end
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [15:0] random_origin();
    if ($urandom_range(99) < 70) begin
      return 16'($urandom_range(16000)) - 16'd8000;
    end
    return 16'($urandom());
  endfunction

  function automatic logic [11:0] random_cell();
    int r;
    r = $urandom_range(99);
    if (r < 10) begin
      return 12'd0;
    end else if (r < 80) begin
      return 12'($urandom_range(64, 1));
    end else if (r < 90) begin
      return 12'($urandom_range(400, 65));
    end
    return 12'($urandom_range(4095));
  endfunction

  // Before any first character the pen, pitch and colour come from reset.
  task automatic test_reset_defaults();
    send_char("H", 1'b0, 16'($urandom()), 16'($urandom()), 12'($urandom()), $urandom());
    send_char("8", 1'b0, 16'($urandom()), 16'($urandom()), 12'($urandom()), $urandom());
  endtask

  task automatic test_glyph_set();
    logic [7:0] codes [14];
    codes = '{"Z", " ", "0", "9", ":", ".", "-", "_", 8'h00, 8'h7F, 8'h80, 8'hFF, "z", "@"};
    send_char("a", 1'b1, 16'h0000, 16'h0000, 12'd0, 32'hFFFF_FFFF);
    foreach (codes[k]) begin
      send_char(codes[k], 1'b0, 16'hFFFF, 16'hFFFF, 12'hFFF, 32'h0);
    end
  endtask

  task automatic test_coordinate_limits();
    send_char("M", 1'b1, 16'h8000, 16'h8000, 12'hFFF, 32'h0000_0000);
    send_char("W", 1'b0, 16'h0, 16'h0, 12'h0, 32'h0);
    send_char("B", 1'b1, 16'sd32000, 16'h7FFF, 12'hFFF, 32'hA5A5_5A5A);
    send_char("8", 1'b0, 16'h0, 16'h0, 12'h0, 32'h0);
    send_char("#", 1'b0, 16'h0, 16'h0, 12'h0, 32'h0);
    send_char("I", 1'b1, 16'h1234, 16'hEDCB, 12'd1, 32'h5A5A_A5A5);
  endtask

  task automatic test_drain_pause();
    send_char("O", 1'b1, 16'h0100, 16'h0200, 12'd16, 32'h1122_3344);
    send_char("K", 1'b0, 16'h0, 16'h0, 12'h0, 32'h0);
    send_char(" ", 1'b0, 16'h0, 16'h0, 12'h0, 32'h0);
    drain_dots();
    send_char("Q", 1'b0, 16'h0, 16'h0, 12'h0, 32'h0);
  endtask

  task automatic test_random_text(input int count, input bit quiet);
    int  sent;
    int  len;
    bit  head_first;
    calm = quiet;
    sent = 0;
    while (sent < count) begin
      len = $urandom_range(8, 1);
      head_first = ($urandom_range(9) != 0);
      for (int k = 0; k < len && sent < count; k++) begin
        if (k == 0 && head_first) begin
          send_char(random_code(), 1'b1, random_origin(), random_origin(), random_cell(),
                    $urandom());
        end else begin
          send_char(random_code(), 1'b0, 16'($urandom()), 16'($urandom()),
                    12'($urandom()), $urandom());
        end
        sent++;
      end
    end
    calm = 1'b0;
  endtask

  always @(negedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(99) >= IdlePercent);
  end

  always @(posedge clk_i) begin
    glyph_dot_t got;
    glyph_dot_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_dots(s_axis_tdata[7:0], s_axis_tuser, s_axis_tdata[23:8],
                     s_axis_tdata[39:24], s_axis_tdata[51:40], s_axis_tdata[83:52]);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.x = m_axis_tdata[15:0];
        got.y = m_axis_tdata[31:16];
        got.size = m_axis_tdata[43:32];
        got.color = m_axis_tdata[75:44];
        got.last = m_axis_tlast;
        if (expected_dots.size() == 0) begin
          mismatches++;
          if (mismatches <= ReportLimit) begin
            $display("Dot %0d with nothing expected: x=%0d y=%0d size=%0d color=%h last=%0b",
                     dots_checked, got.x, got.y, got.size, got.color, got.last);
          end
        end else begin
          want = expected_dots.pop_front();
          if (got.x !== want.x || got.y !== want.y || got.size !== want.size ||
              got.color !== want.color || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= ReportLimit) begin
              $display("Dot %0d mismatch: expected x=%0d y=%0d size=%0d color=%h last=%0b",
                       dots_checked, want.x, want.y, want.size, want.color, want.last);
              $display("               actual   x=%0d y=%0d size=%0d color=%h last=%0b",
                       got.x, got.y, got.size, got.color, got.last);
            end
          end
        end
        dots_checked++;
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Watchdog: no request moved for %0d cycles", WatchdogLimit);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    m_axis_tready = 1'b0;
    calm          = 1'b0;
    mismatches    = 0;
    items_sent    = 0;
    dots_checked  = 0;
    quiet_cycles  = 0;
    pen_x    = '0;
    pen_y    = '0;
    pitch    = DefaultPitch;
    dot_side = 12'((int'(DefaultPitch) * DotScale) >> 8);
    ink      = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_glyph_set();
    test_coordinate_limits();
    directed_items = items_sent;
    test_drain_pause();
    test_random_text(50, 1'b0);
    test_random_text(30, 1'b1);
    test_random_text(50, 1'b0);

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    drain_dots();
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d characters (%0d directed: reset defaults, every glyph class, limits),",
             items_sent, directed_items);
    $display("checked %0d dots under random stalls on both sides; %0d mismatches.",
             dots_checked, mismatches);
    if (mismatches == 0 && expected_dots.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d dots still expected at the end", expected_dots.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
sv/gde_pkg.sv
sv/gde_front.sv
sv/gde_queue.sv
sv/gde_back.sv
sv/glyph_dot_emitter_5x7.sv
test/glyph_dot_emitter_5x7_tb.sv
